@@ rtl/core/rli_pkg.sv @@
// ----------------------------------------------------------------------------
// rli_pkg
// Shared types and constants of the rectangle list intersector: coordinate
// widths, item kinds, and the packed layouts of a rectangle and of a result.
// ----------------------------------------------------------------------------
package rli_pkg;

    localparam int MAX_CLIP_RECTS = 32;
    localparam int COORD_W        = 16;
    localparam int TOTAL_W        = 16;

    typedef logic [1:0] mode_t;

    localparam mode_t MODE_CLEAR  = 2'd0;
    localparam mode_t MODE_APPEND = 2'd1;
    localparam mode_t MODE_HINT   = 2'd2;

    // Left edge sits in the lowest bits.
    typedef struct packed {
        logic signed [COORD_W-1:0] bottom;
        logic signed [COORD_W-1:0] right;
        logic signed [COORD_W-1:0] top;
        logic signed [COORD_W-1:0] left;
    } rect_t;

    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        rect_t              rect;
    } result_t;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

endpackage

@@ rtl/core/rect_list_intersector_unit.sv @@
// ----------------------------------------------------------------------------
// rect_list_intersector_unit
// Keeps a list of clip rectangles in a synchronous memory and intersects each
// hint rectangle with every stored entry, one memory read per cycle while the
// output does not stall the walk. Clear and append items are done in idle and
// leave the block ready for the next item. A hint item walks the stored clip
// rectangles through the single memory read port. Each hit is held back
// until the next hit or the end of the walk, so the first result passes the
// memory read register, the pending register and the output register.
// Results wait in an output register, so a stalled result holds up the walk only when another result must be sent.
// Reset (aresetn low, synchronous) empties the list and zeroes the total;
// memory contents are not cleared.
// ----------------------------------------------------------------------------
module rect_list_intersector_unit #(
    parameter int MAX_CLIP_RECTS = rli_pkg::MAX_CLIP_RECTS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // rect_left, rect_top, rect_right, rect_bottom
    input  logic        s_tlast,   // final_hint
    input  logic [1:0]  s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // out_left, out_top, out_right, out_bottom, total_produced
    output logic        m_tlast,   // run_last
    output logic [1:0]  m_tuser    // out_valid, request_done
);

    localparam int CNT_W = $clog2(MAX_CLIP_RECTS + 1);
    localparam int IDX_W = (MAX_CLIP_RECTS > 1) ? $clog2(MAX_CLIP_RECTS) : 1;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_FLUSH = 3'b100
    } state_t;

    rli_pkg::rect_t mem [MAX_CLIP_RECTS];

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       rd_idx_reg, rd_idx_next;
    logic                   data_vld_reg, data_vld_next;
    logic [rli_pkg::TOTAL_W-1:0] total_reg, total_next;
    rli_pkg::rect_t         hint_reg, hint_next;
    logic                   fin_reg, fin_next;
    logic                   pend_vld_reg, pend_vld_next;
    rli_pkg::result_t       pend_reg, pend_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    rli_pkg::result_t       m_tdata_reg, m_tdata_next;
    logic                   m_tlast_reg, m_tlast_next;
    logic [1:0]             m_tuser_reg, m_tuser_next;
    rli_pkg::rect_t         rd_data_reg;

    rli_pkg::rect_t         clip;
    rli_pkg::rect_t         isect;
    logic [rli_pkg::TOTAL_W-1:0] total_inc;
    logic                   hit, out_free, push, stall, more, rd_en, wr_en;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb begin
        clip = rd_data_reg;
        hit = data_vld_reg &&
              (hint_reg.left < clip.right) && (hint_reg.right > clip.left) &&
              (hint_reg.top < clip.bottom) && (hint_reg.bottom > clip.top);
        isect.left   = (hint_reg.left > clip.left) ? hint_reg.left : clip.left;
        isect.top    = (hint_reg.top > clip.top) ? hint_reg.top : clip.top;
        isect.right  = (hint_reg.right < clip.right) ? hint_reg.right : clip.right;
        isect.bottom = (hint_reg.bottom < clip.bottom) ? hint_reg.bottom : clip.bottom;
        total_inc = (total_reg == rli_pkg::TOTAL_MAX) ? total_reg
                                                      : total_reg + 1'b1;
        out_free = !m_tvalid_reg || m_tready;
        push     = hit && pend_vld_reg;
        stall    = push && !out_free;
        more     = rd_idx_reg < count_reg;
        rd_en    = (state_reg == ST_SCAN) && !stall && more;
        wr_en    = s_tvalid && s_tready && (s_tuser == rli_pkg::MODE_APPEND) &&
                   (count_reg < CNT_W'(MAX_CLIP_RECTS));
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        rd_idx_next   = rd_idx_reg;
        data_vld_next = data_vld_reg;
        total_next    = total_reg;
        hint_next     = hint_reg;
        fin_next      = fin_reg;
        pend_vld_next = pend_vld_reg;
        pend_next     = pend_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        m_tuser_next  = m_tuser_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    case (s_tuser)
                        rli_pkg::MODE_CLEAR: begin
                            count_next = '0;
                            total_next = '0;
                        end
                        rli_pkg::MODE_APPEND: begin
                            if (wr_en) begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        rli_pkg::MODE_HINT: begin
                            hint_next     = s_tdata;
                            fin_next      = s_tlast;
                            rd_idx_next   = '0;
                            data_vld_next = 1'b0;
                            pend_vld_next = 1'b0;
                            state_next    = ST_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (!stall) begin
                    data_vld_next = rd_en;
                    if (rd_en) begin
                        rd_idx_next = rd_idx_reg + 1'b1;
                    end
                    if (hit) begin
                        pend_vld_next = 1'b1;
                        pend_next     = {total_inc, isect};
                        total_next    = total_inc;
                    end
                    if (push) begin
                        m_tvalid_next = 1'b1;
                        m_tdata_next  = pend_reg;
                        m_tlast_next  = 1'b0;
                        m_tuser_next  = 2'b01;
                    end
                    if (!rd_en) begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tlast_next  = 1'b1;
                    if (pend_vld_reg) begin
                        m_tdata_next = pend_reg;
                        m_tuser_next = {fin_reg, 1'b1};
                    end else begin
                        m_tdata_next = {total_reg, 64'd0};
                        m_tuser_next = {fin_reg, 1'b0};
                    end
                    pend_vld_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[count_reg[IDX_W-1:0]] <= s_tdata;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_idx_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            rd_idx_reg   <= '0;
            data_vld_reg <= 1'b0;
            total_reg    <= '0;
            pend_vld_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            rd_idx_reg   <= rd_idx_next;
            data_vld_reg <= data_vld_next;
            total_reg    <= total_next;
            pend_vld_reg <= pend_vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hint_reg    <= hint_next;
        fin_reg     <= fin_next;
        pend_reg    <= pend_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
        m_tuser_reg <= m_tuser_next;
    end

    // The list never grows past its capacity.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_CLIP_RECTS))
        else $error("clip count above capacity");

    // The walk never reads beyond the stored entries.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> rd_idx_reg <= count_reg)
        else $error("read index past clip count");

    // No result is left pending once the block is idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !pend_vld_reg)
        else $error("pending result lost");

    // An empty result always closes its run.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !m_tuser_reg[0] |-> m_tlast_reg)
        else $error("invalid result without run end");

    // During a walk the total grows by at most one per cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |=>
            (total_reg == $past(total_reg)) || (total_reg == $past(total_reg) + 1'b1))
        else $error("total jumped during walk");

endmodule
